[rtl/lrus_pkg.sv]
// Shared constants and types for the LRU recency stack.
package lrus_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_W     = 32;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CAP_W     = 5;
   localparam int RANK_W    = 4;
   localparam int OCC_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Per-cell control from the top level
   typedef struct packed {
      logic live;   // cell holds one of the valid keys
      logic shift;  // load the key from the neighbor in front
      logic last;   // cell holds the back key
   } cell_ctl_type;

endpackage

[rtl/lrus_ifs.sv]
// Handshake channel interfaces for requests, responses and the capacity register.
interface lrus_req_if;
   logic                  valid;
   logic                  ready;
   logic [lrus_pkg::KEY_W-1:0] key;
   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface lrus_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lrus_pkg::RANK_W-1:0] hit_rank;
   logic                        evicted;
   logic [lrus_pkg::KEY_W-1:0]  evicted_key;
   logic [lrus_pkg::OCC_W-1:0]  occupancy;
   modport source (output valid, output hit, output hit_rank, output evicted,
                   output evicted_key, output occupancy, input ready);
   modport sink   (input valid, input hit, input hit_rank, input evicted,
                   input evicted_key, input occupancy, output ready);
endinterface

interface lrus_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lrus_pkg::CAP_W-1:0] capacity;
   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

[rtl/lru_recency_stack_top.sv]
// Top level of the LRU recency stack: cell row, occupancy control and response register.
// A request transfer updates the stack and registers its response.
// Throughput: 1 request per cycle; all cells compare and shift in parallel in that cycle.
// A new request is taken only when no response waits or the waiting one transfers.
// Reset: occupancy 0, capacity 5, no response pending; stored keys are not cleared.
module lru_recency_stack_top (
   input  logic        clock,
   input  logic        reset,
   lrus_req_if.sink    req_chan,
   lrus_rsp_if.source  rsp_chan,
   lrus_csr_if.sink    csr_chan
);
   import lrus_pkg::*;

   cnt_type             count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff;
   logic                rsp_valid_ff;
   logic                hit_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic                evict_ff;
   key_type             evict_key_ff;
   logic [OCC_W-1:0]    occ_ff;

   logic                accept;
   key_type             req_key;
   cnt_type             limit;
   cnt_type             shift_limit;
   logic [ENTRIES-1:0]  match;
   logic                hit;
   logic [IDX_W-1:0]    rank;
   logic                drop;
   key_type             back_key;
   key_type             drop_key;
   key_type             cell_key  [ENTRIES];
   key_type             cell_back [ENTRIES];
   cell_ctl_type        cell_ctl  [ENTRIES];

   assign req_key        = req_chan.key;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Clamp capacity to the stack depth
   assign limit = (cap_ff > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(cap_ff);

   // Collect hit flag, hit position and back key from the cells
   always_comb begin
      hit      = 1'b0;
      rank     = '0;
      back_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit      = hit | match[i];
         rank     = rank | (match[i] ? IDX_W'(i) : '0);
         back_key = back_key | cell_back[i];
      end
   end

   // Decide shift range, eviction and the next occupancy
   always_comb begin
      drop = !hit && (count_ff >= limit);
      if (hit) begin
         shift_limit = CNT_W'(rank);
      end else if (count_ff >= CNT_W'(ENTRIES)) begin
         shift_limit = CNT_W'(ENTRIES - 1);
      end else begin
         shift_limit = count_ff;
      end
      drop_key = (count_ff == '0) ? req_key : back_key;
      count_in = count_ff;
      if (accept && !hit && !drop) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Build the cell row; the front cell takes the request key
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      assign cell_ctl[g].live  = CNT_W'(g) < count_ff;
      assign cell_ctl[g].shift = accept && (CNT_W'(g) <= shift_limit);
      assign cell_ctl[g].last  = (CNT_W'(g) + CNT_W'(1)) == count_ff;

      lrus_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[g]),
         .prev_key ((g == 0) ? req_key : cell_key[(g == 0) ? 0 : g - 1]),
         .req_key  (req_key),
         .key_out  (cell_key[g]),
         .match    (match[g]),
         .back_key (cell_back[g])
      );
   end

   // Hold control state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_chan.valid) begin
            cap_ff <= csr_chan.capacity;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         hit_ff       <= hit;
         rank_ff      <= hit ? RANK_W'(rank) : '0;
         evict_ff     <= drop;
         evict_key_ff <= drop ? drop_key : '0;
         occ_ff       <= OCC_W'(count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = hit_ff;
   assign rsp_chan.hit_rank    = rank_ff;
   assign rsp_chan.evicted     = evict_ff;
   assign rsp_chan.evicted_key = evict_key_ff;
   assign rsp_chan.occupancy   = occ_ff;

endmodule

[rtl/lrus_cell.sv]
// One recency stack cell: holds a key, compares it, takes its neighbor's key on shift.
module lrus_cell (
   input  logic                   clock,
   input  lrus_pkg::cell_ctl_type ctl,
   input  lrus_pkg::key_type      prev_key,
   input  lrus_pkg::key_type      req_key,
   output lrus_pkg::key_type      key_out,
   output logic                   match,
   output lrus_pkg::key_type      back_key
);
   import lrus_pkg::*;

   key_type key_ff;
   key_type key_in;

   // Advance the neighbor's key when told to shift, else hold
   always_comb begin
      key_in = ctl.shift ? prev_key : key_ff;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // Compare against the request and drive the back key onto the OR bus
   assign match    = ctl.live && (key_ff == req_key);
   assign back_key = ctl.last ? key_ff : '0;
   assign key_out  = key_ff;

endmodule
